// ===== sv/tac_pkg.sv =====
// Shared types and constants of the text attribute to ANSI console unit.
package tac_pkg;

    localparam int MaxBytes = 16;
    localparam int IdxW     = $clog2(MaxBytes);
    localparam int LenW     = $clog2(MaxBytes + 1);

    localparam logic [2:0] CMD_PUT_CHAR = 3'd0;
    localparam logic [2:0] CMD_SET_ATTR = 3'd1;
    localparam logic [2:0] CMD_GOTO     = 3'd2;
    localparam logic [2:0] CMD_CLR_EOL  = 3'd3;
    localparam logic [2:0] CMD_CLR_SCR  = 3'd4;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [7:0] RESET_WIDTH  = 8'd80;
    localparam logic [7:0] RESET_HEIGHT = 8'd24;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B; // '['
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_TWO  = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR = 8'h34;
    localparam logic [7:0] CH_FIVE = 8'h35;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_J    = 8'h4A;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] UTF_B0  = 8'hE2;
    localparam logic [7:0] UTF_B1  = 8'h86;
    localparam logic [7:0] UTF_UP  = 8'h91;
    localparam logic [7:0] UTF_DN  = 8'h93;

    // one command's worth of terminal bytes; len of zero is an empty result
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [LenW-1:0]          len;
    } tac_entry_t;

endpackage

// ===== sv/tac_in_if.sv =====
// Command channel: valid/ready plus the console command fields.
interface tac_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] char_code;
    logic [7:0] attr_value;
    logic [7:0] col;
    logic [7:0] row;

    modport source (output valid, command, char_code, attr_value, col, row, input ready);
    modport sink   (input valid, command, char_code, attr_value, col, row, output ready);
endinterface

// ===== sv/tac_out_if.sv =====
// Terminal byte channel: valid/ready plus one byte, its flag and last.
interface tac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, out_byte, byte_valid, last, input ready);
    modport sink   (input valid, out_byte, byte_valid, last, output ready);
endinterface

// ===== sv/tac_front.sv =====
// Front end: accepts commands, tracks cursor and attribute, builds the byte string.
module tac_front
    import tac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tac_in_if.sink     cmd,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       q_full,
    output logic       q_push,
    output tac_entry_t q_entry
);

    logic [7:0] width_reg, height_reg;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    logic [7:0] attr_reg, attr_next;

    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          pos;
    logic [LenW-1:0]          len;
    logic [7:0]               old_a;
    logic [7:0]               a;
    logic [7:0]               row_dn;
    logic                     accept;

    function automatic logic [2:0] bgr(input logic [2:0] c);
        bgr = {c[0], c[1], c[2]};
    endfunction

    // decimal split: hundreds by compare, tens by reciprocal multiply
    function automatic logic [11:0] dec_split(input logic [7:0] v);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [7:0]  o;
        h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r    = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
        prod = {8'd0, r[6:0]} * 15'd205;
        t    = prod[14:11];
        o    = r - 8'({t, 3'b000} + {t, 1'b0});
        dec_split = {2'b00, h, t, o[3:0]};
    endfunction

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;
    assign q_push    = accept;
    assign row_dn    = (row_reg < height_reg) ? row_reg + 8'd1 : row_reg;
    assign a         = cmd.attr_value;

    always_comb
    begin
        logic [11:0] dr, dc;
        bytes     = '0;
        pos       = '0;
        len       = '0;
        old_a     = attr_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        attr_next = attr_reg;
        dr        = dec_split(cmd.row);
        dc        = dec_split(cmd.col);
        unique case (cmd.command)
            CMD_PUT_CHAR:
            begin
                if (cmd.char_code == 8'd24 || cmd.char_code == 8'd25)
                begin
                    bytes[0] = UTF_B0;
                    bytes[1] = UTF_B1;
                    bytes[2] = (cmd.char_code == 8'd24) ? UTF_UP : UTF_DN;
                    len      = LenW'(3);
                end
                else
                begin
                    bytes[0] = cmd.char_code;
                    len      = LenW'(1);
                end
                priority case (cmd.char_code)
                    8'd13: col_next = 8'd1;
                    8'd10: row_next = row_dn;
                    8'd7, 8'd127: ;
                    8'd8:
                    begin
                        if (col_reg > 8'd1)
                            col_next = col_reg - 8'd1;
                    end
                    default:
                    begin
                        if (col_reg < width_reg)
                            col_next = col_reg + 8'd1;
                        else
                        begin
                            col_next = 8'd1;
                            row_next = row_dn;
                        end
                    end
                endcase
            end
            CMD_SET_ATTR:
            begin
                if (a != attr_reg)
                begin
                    attr_next = a;
                    if (a == RESET_ATTR)
                    begin
                        bytes[0] = CH_ESC;
                        bytes[1] = CH_LBR;
                        bytes[2] = CH_M;
                        len      = LenW'(3);
                    end
                    else
                    begin
                        bytes[0] = CH_ESC;
                        bytes[1] = CH_LBR;
                        pos      = LenW'(2);
                        if (!a[3] && old_a[3])
                        begin
                            bytes[pos[IdxW-1:0]] = CH_ZERO; pos = pos + 1'b1;
                            bytes[pos[IdxW-1:0]] = CH_SEMI; pos = pos + 1'b1;
                            old_a = RESET_ATTR;
                        end
                        if ((a[6:4] ^ old_a[6:4]) != 3'd0)
                        begin
                            if (a[7:4] == 4'd0)
                            begin
                                bytes[pos[IdxW-1:0]] = CH_ZERO; pos = pos + 1'b1;
                                bytes[pos[IdxW-1:0]] = CH_SEMI; pos = pos + 1'b1;
                                old_a = RESET_ATTR;
                            end
                            else
                            begin
                                bytes[pos[IdxW-1:0]] = CH_FOUR; pos = pos + 1'b1;
                                bytes[pos[IdxW-1:0]] = CH_ZERO | {5'd0, bgr(a[6:4])};
                                pos = pos + 1'b1;
                                bytes[pos[IdxW-1:0]] = CH_SEMI; pos = pos + 1'b1;
                            end
                        end
                        if (a[3:0] == 4'd14 && old_a[3:0] != 4'd14)
                        begin
                            // 256-color orange stands in for yellow
                            bytes[pos[IdxW-1:0]] = CH_THREE; pos = pos + 1'b1;
                            bytes[pos[IdxW-1:0]] = CH_EIGHT; pos = pos + 1'b1;
                            bytes[pos[IdxW-1:0]] = CH_SEMI;  pos = pos + 1'b1;
                            bytes[pos[IdxW-1:0]] = CH_FIVE;  pos = pos + 1'b1;
                            bytes[pos[IdxW-1:0]] = CH_SEMI;  pos = pos + 1'b1;
                            bytes[pos[IdxW-1:0]] = CH_ONE;   pos = pos + 1'b1;
                            bytes[pos[IdxW-1:0]] = CH_SEVEN; pos = pos + 1'b1;
                            bytes[pos[IdxW-1:0]] = CH_TWO;   pos = pos + 1'b1;
                            bytes[pos[IdxW-1:0]] = CH_SEMI;  pos = pos + 1'b1;
                        end
                        else
                        begin
                            if (a[3] && (!old_a[3] || old_a[3:0] == 4'd14))
                            begin
                                bytes[pos[IdxW-1:0]] = CH_ONE;  pos = pos + 1'b1;
                                bytes[pos[IdxW-1:0]] = CH_SEMI; pos = pos + 1'b1;
                            end
                            if ((a[2:0] ^ old_a[2:0]) != 3'd0)
                            begin
                                bytes[pos[IdxW-1:0]] = CH_THREE; pos = pos + 1'b1;
                                bytes[pos[IdxW-1:0]] = CH_ZERO | {5'd0, bgr(a[2:0])};
                                pos = pos + 1'b1;
                                bytes[pos[IdxW-1:0]] = CH_SEMI; pos = pos + 1'b1;
                            end
                        end
                        // trailing ';' becomes 'm'; no parameter means empty result
                        if (pos > LenW'(2))
                        begin
                            bytes[pos[IdxW-1:0] - 1'b1] = CH_M;
                            len = pos;
                        end
                    end
                end
            end
            CMD_GOTO:
            begin
                col_next = cmd.col;
                row_next = cmd.row;
                bytes[0] = CH_ESC;
                bytes[1] = CH_LBR;
                if (cmd.col == 8'd1 && cmd.row == 8'd1)
                begin
                    bytes[2] = CH_H;
                    len      = LenW'(3);
                end
                else
                begin
                    pos = LenW'(2);
                    if (cmd.row >= 8'd100)
                    begin
                        bytes[pos[IdxW-1:0]] = CH_ZERO | {6'd0, dr[9:8]}; pos = pos + 1'b1;
                    end
                    if (cmd.row >= 8'd10)
                    begin
                        bytes[pos[IdxW-1:0]] = CH_ZERO | {4'd0, dr[7:4]}; pos = pos + 1'b1;
                    end
                    bytes[pos[IdxW-1:0]] = CH_ZERO | {4'd0, dr[3:0]}; pos = pos + 1'b1;
                    bytes[pos[IdxW-1:0]] = CH_SEMI; pos = pos + 1'b1;
                    if (cmd.col >= 8'd100)
                    begin
                        bytes[pos[IdxW-1:0]] = CH_ZERO | {6'd0, dc[9:8]}; pos = pos + 1'b1;
                    end
                    if (cmd.col >= 8'd10)
                    begin
                        bytes[pos[IdxW-1:0]] = CH_ZERO | {4'd0, dc[7:4]}; pos = pos + 1'b1;
                    end
                    bytes[pos[IdxW-1:0]] = CH_ZERO | {4'd0, dc[3:0]}; pos = pos + 1'b1;
                    bytes[pos[IdxW-1:0]] = CH_H; pos = pos + 1'b1;
                    len = pos;
                end
            end
            CMD_CLR_EOL:
            begin
                bytes[0] = CH_ESC;
                bytes[1] = CH_LBR;
                bytes[2] = CH_K;
                len      = LenW'(3);
            end
            CMD_CLR_SCR:
            begin
                bytes[0] = CH_ESC;
                bytes[1] = CH_LBR;
                bytes[2] = CH_TWO;
                bytes[3] = CH_J;
                bytes[4] = CH_ESC;
                bytes[5] = CH_LBR;
                bytes[6] = CH_H;
                len      = LenW'(7);
                col_next = 8'd1;
                row_next = 8'd1;
            end
            default: ; // unused codes: empty result, no state change
        endcase
    end

    assign q_entry.bytes = bytes;
    assign q_entry.len   = len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            col_reg    <= 8'd1;
            row_reg    <= 8'd1;
            attr_reg   <= RESET_ATTR;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
            end
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                attr_reg <= attr_next;
            end
        end
    end

endmodule

// ===== sv/tac_queue.sv =====
// Two-entry queue of built byte strings between front and back.
module tac_queue
    import tac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tac_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output tac_entry_t head
);

    tac_entry_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/tac_back.sv =====
// Back end: serializes the queue head, one byte per beat, into a registered output.
module tac_back
    import tac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  tac_entry_t q_head,
    output logic       q_pop,
    tac_out_if.source  tx
);

    logic            valid_reg;
    logic [7:0]      byte_reg;
    logic            bvalid_reg;
    logic            last_reg;
    logic [IdxW-1:0] idx_reg;
    logic            load;
    logic            is_empty;
    logic            at_end;

    assign load     = q_not_empty && (!valid_reg || tx.ready);
    assign is_empty = (q_head.len == '0);
    assign at_end   = is_empty || ((LenW'(idx_reg) + 1'b1) == q_head.len);
    assign q_pop    = load && at_end;

    assign tx.valid      = valid_reg;
    assign tx.out_byte   = byte_reg;
    assign tx.byte_valid = bvalid_reg;
    assign tx.last       = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= is_empty ? 8'd0 : q_head.bytes[idx_reg];
            bvalid_reg <= !is_empty;
            last_reg   <= at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? '0 : idx_reg + 1'b1;
            end
            else if (tx.ready)
                valid_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/text_attribute_to_ansi_console_unit.sv =====
// Top level of the text attribute to ANSI console unit.
//
// Takes PC text-console commands (put char, set attribute, goto, clear to end
// of line, clear screen) on the cmd channel and sends the matching ANSI
// terminal bytes on the tx channel, one byte per beat, with last set on the
// final beat of each command. A command that produces nothing (unchanged
// attribute, an attribute change needing no parameter, or an unused command
// code) gives one beat with byte_valid low and last high. The front end takes
// a command every cycle while the two-entry queue has room, updates cursor and
// attribute at once and builds the whole byte string; the back end drains one
// byte per cycle while the tx side is ready. A command gives 1 to 14 output
// beats (typically 1 to 3); the back-end serializer sets the rate.
// Output is registered, so a stalled tx side never holds up the front end
// until the queue fills. Configuration (cfg_index 0: screen width,
// 1: screen height) is written through cfg_we/cfg_index/cfg_data while idle.
module text_attribute_to_ansi_console_unit
    import tac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tac_in_if.sink     cmd,
    tac_out_if.source  tx,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    tac_entry_t q_in;
    tac_entry_t q_head;

    // classify, update state, build bytes
    tac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    // decouples command intake from byte output
    tac_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // byte serializer with registered output stage
    tac_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .tx          (tx)
    );

endmodule
